// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the scan sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising clock edge outside reset.
`define ARSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that expr never holds outside reset.
`define ARSS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ARSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARSS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== design/arss_pkg.sv =====
// ----------------------------------------------------------------------------
// arss_pkg
// Types and constants of the ADC round-robin scan sequencer.
// ----------------------------------------------------------------------------
package arss_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int CH_BITS          = 3;
    localparam int SAMPLE_BITS      = 24;

    // Input event codes
    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_DRDY  = 3'd1,
        MODE_RX    = 3'd2,
        MODE_QUERY = 3'd3,
        MODE_APPLY = 3'd4,
        MODE_ID    = 3'd5
    } t_mode;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SPI    = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_ID     = 2'd3
    } t_kind;

    // Pending read
    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_DATA = 2'd1,
        RD_ID   = 2'd2
    } t_rd_kind;

    // Result run loaded by one input item
    typedef enum logic [2:0] {
        JOB_DRDY,
        JOB_APPLY,
        JOB_RDID,
        JOB_SAMPLE,
        JOB_QUERY,
        JOB_CHIPID
    } t_job;

    // Converter command and register bytes
    localparam logic [7:0] CMD_WREG_STATUS = 8'h50;
    localparam logic [7:0] CMD_WREG_MUX    = 8'h51;
    localparam logic [7:0] CMD_RREG_STATUS = 8'h10;
    localparam logic [7:0] OP_SYNC         = 8'hFC;
    localparam logic [7:0] OP_WAKEUP       = 8'h00;
    localparam logic [7:0] OP_READ_DATA    = 8'h01;
    localparam logic [7:0] BYTE_ZERO       = 8'h00;
    localparam logic [7:0] BYTE_DUMMY      = 8'hFF;
    localparam logic [7:0] WREG_COUNT4     = 8'h03;
    localparam logic [7:0] STATUS_CFG      = 8'h04;
    localparam logic [7:0] MUX_CFG         = 8'h08;
    localparam logic [3:0] MUX_NEG_COMMON  = 4'h8;

    localparam logic [7:0] DRATE_RESET     = 8'd240;

    // Last result index of each run
    localparam logic [3:0] LAST_DRDY  = 4'd8;
    localparam logic [3:0] LAST_APPLY = 4'd5;
    localparam logic [3:0] LAST_RDID  = 4'd2;

    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              tx_byte;
        logic                    expects_reply;
        logic                    frame_end;
        logic [SAMPLE_BITS-1:0]  sample_value;
        logic [CH_BITS-1:0]      sample_channel;
        logic [3:0]              chip_id;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic                    clr;
        logic                    we;
        logic [CH_BITS-1:0]      wr_addr;
        logic [SAMPLE_BITS-1:0]  wr_data;
        logic                    re;
        logic [CH_BITS-1:0]      rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic [2:0] pga_gain_code;
        logic [7:0] data_rate_code;
    } t_cfg;

endpackage

// ===== design/arss_sample_mem.sv =====
// ----------------------------------------------------------------------------
// arss_sample_mem
// Sample table: one write port, one registered read port, per-entry valid.
// ----------------------------------------------------------------------------
module arss_sample_mem #(
    parameter int NUM_CHANNELS = arss_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  arss_pkg::t_mem_req                  i_req,
    output logic [arss_pkg::SAMPLE_BITS-1:0]    o_rd_data
);

    localparam int CH_W = $clog2(NUM_CHANNELS);

    logic [arss_pkg::SAMPLE_BITS-1:0] mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]          r_valid;
    logic [arss_pkg::SAMPLE_BITS-1:0] r_rd_data;
    logic                             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wr_addr[CH_W-1:0]] <= i_req.wr_data;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.rd_addr[CH_W-1:0]];
        end
    end

    // Entries not written since reset or start-scan read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.we) begin
                r_valid[i_req.wr_addr[CH_W-1:0]] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_valid <= r_valid[i_req.rd_addr[CH_W-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== design/arss_seq.sv =====
// ----------------------------------------------------------------------------
// arss_seq
// Event decode, scan/read state update and result run generation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arss_seq #(
    parameter int NUM_CHANNELS = arss_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_mode,
    input  logic [7:0]                          i_rx_byte,
    input  logic [3:0]                          i_query_channel,
    input  arss_pkg::t_cfg                      i_cfg,
    output arss_pkg::t_mem_req                  o_mem_req,
    input  logic [arss_pkg::SAMPLE_BITS-1:0]    i_mem_rd_data,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output arss_pkg::t_result                   o_res
);

    localparam logic [arss_pkg::CH_BITS-1:0] LAST_CH = arss_pkg::CH_BITS'(NUM_CHANNELS - 1);
    localparam logic [3:0]                   NUM_Q   = 4'(NUM_CHANNELS);

    // Scan and read state
    logic [arss_pkg::CH_BITS-1:0] r_cur_ch,  n_cur_ch;
    logic [1:0]                   r_phase,   n_phase;
    arss_pkg::t_rd_kind           r_pend,    n_pend;
    logic [15:0]                  r_partial, n_partial;

    // Result run in progress
    logic                             r_job_valid, n_job_valid;
    arss_pkg::t_job                   r_job,       n_job;
    logic [3:0]                       r_idx,       n_idx;
    logic [arss_pkg::CH_BITS-1:0]     r_chan,      n_chan;
    logic [arss_pkg::SAMPLE_BITS-1:0] r_word,      n_word;
    logic                             r_qok,       n_qok;

    logic                             acc;
    logic                             load;
    logic                             job_last;
    logic [3:0]                       last_idx;
    logic [arss_pkg::CH_BITS-1:0]     prev_ch;
    logic [arss_pkg::SAMPLE_BITS-1:0] word;

    always_comb begin
        unique case (r_job)
            arss_pkg::JOB_DRDY:  last_idx = arss_pkg::LAST_DRDY;
            arss_pkg::JOB_APPLY: last_idx = arss_pkg::LAST_APPLY;
            arss_pkg::JOB_RDID:  last_idx = arss_pkg::LAST_RDID;
            default:             last_idx = 4'd0;
        endcase
    end

    assign job_last   = (r_idx == last_idx);
    assign o_in_ready = !r_job_valid || (i_res_ready && job_last);
    assign acc        = i_in_valid && o_in_ready;
    assign prev_ch    = (r_cur_ch == '0) ? LAST_CH : r_cur_ch - 1'b1;
    assign word       = {r_partial, i_rx_byte};

    // Decode the accepted event
    always_comb begin
        n_cur_ch  = r_cur_ch;
        n_phase   = r_phase;
        n_pend    = r_pend;
        n_partial = r_partial;
        n_job     = r_job;
        n_chan    = r_chan;
        n_word    = r_word;
        n_qok     = r_qok;
        load      = 1'b0;
        o_mem_req = '0;
        if (acc) begin
            unique case (i_mode)
                arss_pkg::MODE_START: begin
                    o_mem_req.clr = 1'b1;
                    n_cur_ch      = '0;
                    n_phase       = '0;
                    n_pend        = arss_pkg::RD_NONE;
                    n_partial     = '0;
                end
                arss_pkg::MODE_DRDY: begin
                    n_phase   = 2'd1;
                    n_pend    = arss_pkg::RD_DATA;
                    n_partial = '0;
                    load      = 1'b1;
                    n_job     = arss_pkg::JOB_DRDY;
                    n_chan    = r_cur_ch;
                end
                arss_pkg::MODE_RX: begin
                    if (r_phase == '0 || r_pend == arss_pkg::RD_NONE) begin
                        n_phase   = '0;
                        n_pend    = arss_pkg::RD_NONE;
                        n_partial = '0;
                    end else if (r_pend == arss_pkg::RD_ID) begin
                        n_phase   = '0;
                        n_pend    = arss_pkg::RD_NONE;
                        n_partial = '0;
                        load      = 1'b1;
                        n_job     = arss_pkg::JOB_CHIPID;
                        n_word    = {20'd0, i_rx_byte[7:4]};
                    end else if (r_phase != 2'd3) begin
                        n_partial = {r_partial[7:0], i_rx_byte};
                        n_phase   = r_phase + 2'd1;
                    end else begin
                        // Word belongs to the channel selected one event earlier
                        o_mem_req.we      = 1'b1;
                        o_mem_req.wr_addr = prev_ch;
                        o_mem_req.wr_data = word;
                        n_cur_ch  = (r_cur_ch == LAST_CH) ? '0 : r_cur_ch + 1'b1;
                        n_phase   = '0;
                        n_pend    = arss_pkg::RD_NONE;
                        n_partial = '0;
                        load      = 1'b1;
                        n_job     = arss_pkg::JOB_SAMPLE;
                        n_chan    = prev_ch;
                        n_word    = word;
                    end
                end
                arss_pkg::MODE_QUERY: begin
                    load  = 1'b1;
                    n_job = arss_pkg::JOB_QUERY;
                    n_qok = (i_query_channel < NUM_Q);
                    n_chan = n_qok ? i_query_channel[arss_pkg::CH_BITS-1:0] : '0;
                    o_mem_req.re      = n_qok;
                    o_mem_req.rd_addr = i_query_channel[arss_pkg::CH_BITS-1:0];
                end
                arss_pkg::MODE_APPLY: begin
                    n_phase   = '0;
                    n_pend    = arss_pkg::RD_NONE;
                    n_partial = '0;
                    load      = 1'b1;
                    n_job     = arss_pkg::JOB_APPLY;
                end
                arss_pkg::MODE_ID: begin
                    n_phase   = 2'd1;
                    n_pend    = arss_pkg::RD_ID;
                    n_partial = '0;
                    load      = 1'b1;
                    n_job     = arss_pkg::JOB_RDID;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the run; a new one loads as the last result of the old one leaves
    always_comb begin
        n_job_valid = r_job_valid;
        n_idx       = r_idx;
        if (r_job_valid && i_res_ready) begin
            if (job_last) begin
                n_job_valid = 1'b0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
        if (load) begin
            n_job_valid = 1'b1;
            n_idx       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_ch    <= '0;
            r_phase     <= '0;
            r_pend      <= arss_pkg::RD_NONE;
            r_partial   <= '0;
            r_job_valid <= 1'b0;
            r_idx       <= '0;
            r_job       <= arss_pkg::JOB_DRDY;
        end else begin
            r_cur_ch    <= n_cur_ch;
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_partial   <= n_partial;
            r_job_valid <= n_job_valid;
            r_idx       <= n_idx;
            r_job       <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
        r_word <= n_word;
        r_qok  <= n_qok;
    end

    // Result of the current run position
    always_comb begin
        o_res      = '0;
        o_res.last = job_last;
        unique case (r_job)
            arss_pkg::JOB_DRDY: begin
                o_res.kind = arss_pkg::KIND_SPI;
                unique case (r_idx)
                    4'd0: o_res.tx_byte = arss_pkg::CMD_WREG_MUX;
                    4'd1: o_res.tx_byte = arss_pkg::BYTE_ZERO;
                    4'd2: begin
                        o_res.tx_byte   = {1'b0, r_chan, arss_pkg::MUX_NEG_COMMON};
                        o_res.frame_end = 1'b1;
                    end
                    4'd3: begin
                        o_res.tx_byte   = arss_pkg::OP_SYNC;
                        o_res.frame_end = 1'b1;
                    end
                    4'd4: begin
                        o_res.tx_byte   = arss_pkg::OP_WAKEUP;
                        o_res.frame_end = 1'b1;
                    end
                    4'd5: o_res.tx_byte = arss_pkg::OP_READ_DATA;
                    default: begin
                        o_res.tx_byte       = arss_pkg::BYTE_DUMMY;
                        o_res.expects_reply = 1'b1;
                        o_res.frame_end     = job_last;
                    end
                endcase
            end
            arss_pkg::JOB_APPLY: begin
                o_res.kind = arss_pkg::KIND_SPI;
                unique case (r_idx)
                    4'd0: o_res.tx_byte = arss_pkg::CMD_WREG_STATUS;
                    4'd1: o_res.tx_byte = arss_pkg::WREG_COUNT4;
                    4'd2: o_res.tx_byte = arss_pkg::STATUS_CFG;
                    4'd3: o_res.tx_byte = arss_pkg::MUX_CFG;
                    4'd4: o_res.tx_byte = {5'd0, i_cfg.pga_gain_code};
                    default: begin
                        o_res.tx_byte   = i_cfg.data_rate_code;
                        o_res.frame_end = 1'b1;
                    end
                endcase
            end
            arss_pkg::JOB_RDID: begin
                o_res.kind = arss_pkg::KIND_SPI;
                unique case (r_idx)
                    4'd0: o_res.tx_byte = arss_pkg::CMD_RREG_STATUS;
                    4'd1: o_res.tx_byte = arss_pkg::BYTE_ZERO;
                    default: begin
                        o_res.tx_byte       = arss_pkg::BYTE_DUMMY;
                        o_res.expects_reply = 1'b1;
                        o_res.frame_end     = 1'b1;
                    end
                endcase
            end
            arss_pkg::JOB_SAMPLE: begin
                o_res.kind           = arss_pkg::KIND_SAMPLE;
                o_res.sample_value   = r_word;
                o_res.sample_channel = r_chan;
            end
            arss_pkg::JOB_QUERY: begin
                o_res.kind           = arss_pkg::KIND_QUERY;
                o_res.sample_value   = r_qok ? i_mem_rd_data : '0;
                o_res.sample_channel = r_chan;
            end
            default: begin
                o_res.kind    = arss_pkg::KIND_ID;
                o_res.chip_id = r_word[3:0];
            end
        endcase
    end

    assign o_res_valid = r_job_valid;

    `ARSS_ASSERT(a_phase_matches_pend, i_clk, i_rst_n, ((r_phase == 2'd0) == (r_pend == arss_pkg::RD_NONE)), "read phase and pending kind disagree")
    `ARSS_ASSERT(a_id_single_slot, i_clk, i_rst_n, (r_pend == arss_pkg::RD_ID) |-> (r_phase == 2'd1), "status read past its only slot")
    `ARSS_ASSERT(a_idx_in_run, i_clk, i_rst_n, r_job_valid |-> (r_idx <= last_idx), "result index beyond end of run")

endmodule

// ===== design/adc_round_robin_scan_sequencer.sv =====
// ----------------------------------------------------------------------------
// adc_round_robin_scan_sequencer
// Byte-level command sequencer for a multi-channel SPI delta-sigma converter.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one event per transfer; tuser carries the event code
// (start scan, data ready, received byte, query, apply settings, read id),
// tdata the received byte and the query channel.
// Output stream (m_axis): result transfers. tuser gives the kind (serial byte,
// sample stored, query answer, chip id), tlast marks the final result of one
// event. A data-ready event gives nine serial bytes, apply-settings six,
// read-id three; a completed 24-bit reply, a status reply and a query give
// one result each; start scan and partial reply bytes give none.
// The first result of an event is registered in the sequencer run state and
// then in the output register. Results go out at one per cycle while the
// skid entry is free; the next event is taken in the cycle that the last
// result of the current one is emitted. Queries read the sample memory
// through its registered read port. Reset clears the channel pointer, the
// pending read and all table valid bits at once; no clearing pass is needed.
// On a receiver stall the output register and a one-entry skid buffer hold
// results, and s_axis_tready drops once the skid buffer is in use while a
// run is pending. Registers (APB): 0x0 gain code, 0x4 data rate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_round_robin_scan_sequencer #(
    parameter int NUM_CHANNELS = arss_pkg::NUM_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [11:8] query_channel, zero pad
    input  logic [2:0]  s_axis_tuser,   // [2:0] mode
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] tx_byte, [8] expects_reply,
                                        // [9] frame_end, [33:10] sample_value,
                                        // [36:34] sample_channel, [40:37] chip_id
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    // Configuration registers
    logic [2:0] r_gain;
    logic [7:0] r_drate;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= '0;
            r_drate <= arss_pkg::DRATE_RESET;
        end else if (cfg_wr) begin
            // Register index sits in address bit 2
            if (paddr[2]) begin
                r_drate <= pwdata[7:0];
            end else begin
                r_gain <= pwdata[2:0];
            end
        end
    end

    assign prdata = paddr[2] ? {24'd0, r_drate} : {29'd0, r_gain};

    arss_pkg::t_cfg cfg;
    assign cfg.pga_gain_code  = r_gain;
    assign cfg.data_rate_code = r_drate;

    // Sequencer and sample memory
    arss_pkg::t_mem_req               mem_req;
    logic [arss_pkg::SAMPLE_BITS-1:0] mem_rd_data;
    logic                             res_valid;
    logic                             res_ready;
    arss_pkg::t_result                res;

    arss_sample_mem #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    arss_seq #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_mode          (s_axis_tuser),
        .i_rx_byte       (s_axis_tdata[7:0]),
        .i_query_channel (s_axis_tdata[11:8]),
        .i_cfg           (cfg),
        .o_mem_req       (mem_req),
        .i_mem_rd_data   (mem_rd_data),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res)
    );

    // Output register plus skid entry; the sequencer emits only while the
    // skid entry is free, so no path runs from m_axis_tready to s_axis_tready.
    logic              r_out_valid;
    logic              r_skid_valid;
    arss_pkg::t_result r_out;
    arss_pkg::t_result r_skid;
    logic              take;
    logic              emit;

    assign res_ready = !r_skid_valid;
    assign emit      = res_valid && res_ready;
    assign take      = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (emit) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (emit) begin
            if (r_out_valid && !take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {7'd0, r_out.chip_id, r_out.sample_channel, r_out.sample_value,
                            r_out.frame_end, r_out.expects_reply, r_out.tx_byte};

    `ARSS_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid entry full while output register empty")
    `ARSS_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready), "skid entry filled without a stall")
    `ARSS_ASSERT(a_drate_write, i_clk, i_rst_n, (cfg_wr && paddr[2]) |=> (r_drate == $past(pwdata[7:0])), "data rate register write lost")

endmodule
